@@ src/svf_dj_pkg.sv @@
// Shared constants and types for the state-variable DJ filter.
`timescale 1ns / 1ps
`default_nettype none

package svf_dj_pkg;

  // Default widths of the audio samples and integrator states
  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int STATE_WIDTH_DEF  = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // Register indexes
  localparam cfg_idx_t CFG_CUT       = 3'd0;
  localparam cfg_idx_t CFG_COEF_A1   = 3'd1;
  localparam cfg_idx_t CFG_COEF_A2   = 3'd2;
  localparam cfg_idx_t CFG_COEF_A3   = 3'd3;
  localparam cfg_idx_t CFG_DAMPING_K = 3'd4;

  // Register widths
  localparam int CUT_W  = 16;
  localparam int COEF_W = 31;
  localparam int DAMP_W = 32;
  typedef logic signed [CUT_W-1:0] cut_t;
  typedef logic [COEF_W-1:0]       coef_t;
  typedef logic [DAMP_W-1:0]       damp_t;

  // Register reset values (1.0 in Q1.30 and 2.0 in Q2.30)
  localparam coef_t COEF_A1_RST   = 31'h4000_0000;
  localparam damp_t DAMPING_K_RST = 32'h8000_0000;

  // Blend magnitudes below this (0.01 in Q15) bypass the filter
  localparam int BYPASS_LIMIT = 328;

  // Fraction bits of the coefficient and blend products
  localparam int COEF_SH  = 30;
  localparam int BLEND_SH = 15;

  // Shared multiplier: magnitude digit by coefficient operand
  localparam int DIGIT_W = 32;
  localparam int MULC_W  = 32;

endpackage

`default_nettype wire

@@ src/svf_dj_filter_top.sv @@
// Trapezoidal state-variable filter with lowpass/highpass DJ cut and dry/wet blend.
//
// Usage: samples enter on in_valid/in_stall/in_sample_in, results leave on
// out_valid/out_stall/out_sample_out; a transaction completes at a rising
// edge with valid high and stall low. The user must write registers through
// cfg_we/cfg_index/cfg_wdata only while the block is idle; this is not enforced.
// Datapath: one 32x32 multiplier is shared by every product and consumes one
// 32-bit digit of the operand magnitude per cycle, D = ceil((max(S,W)+8)/32)
// digits per product (D = 2 at the default widths). Each product passes
// through operand load, D digit steps, rounding and accumulate; lowpass runs
// five products and highpass six, and a bypassed sample goes straight to the
// output step.
// One sample is in flight at a time; in_stall is low whenever the
// sequencer is idle, also while a finished result still waits in the
// output register. A stalled receiver holds the result there and the
// sequencer waits at its last step until the register is free.
// Reset (rst_n low, synchronous) clears both integrators, empties the
// output register and loads the register defaults (cut 0, a1 1.0, a2 0,
// a3 0, k 2.0).
`timescale 1ns / 1ps
`default_nettype none

module svf_dj_filter_top #(
  parameter int SAMPLE_WIDTH = svf_dj_pkg::SAMPLE_WIDTH_DEF,
  parameter int STATE_WIDTH  = svf_dj_pkg::STATE_WIDTH_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  // Configuration
  input  wire                           cfg_we,
  input  wire svf_dj_pkg::cfg_idx_t     cfg_index,
  input  wire svf_dj_pkg::cfg_data_t    cfg_wdata,
  // Input samples
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire signed [SAMPLE_WIDTH-1:0] in_sample_in,
  // Output samples
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample_out
);

  // Working widths
  localparam int W       = SAMPLE_WIDTH;
  localparam int S       = STATE_WIDTH;
  localparam int V3_W    = ((S > W) ? S : W) + 1;
  localparam int ACC_W   = V3_W + 7;
  localparam int DW      = svf_dj_pkg::DIGIT_W;
  localparam int CW      = svf_dj_pkg::MULC_W;
  localparam int DIGITS  = (ACC_W + DW - 1) / DW;
  localparam int MAG_PAD = DIGITS * DW;
  localparam int PW      = MAG_PAD + CW;
  localparam int CNT_W   = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  // Saturation bounds
  localparam logic signed [ACC_W-1:0] ST_MAX  = ACC_W'((64'sd1 <<< (S-1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] ST_MIN  = ~ST_MAX;
  localparam logic signed [ACC_W-1:0] SMP_MAX = ACC_W'((64'sd1 <<< (W-1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SMP_MIN = ~SMP_MAX;

  // Rounding offsets
  localparam logic [PW-1:0] HALF_C = PW'(64'd1 << (svf_dj_pkg::COEF_SH - 1));
  localparam logic [PW-1:0] HALF_B = PW'(64'd1 << (svf_dj_pkg::BLEND_SH - 1));

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_RND  = 3'd3;
  localparam logic [2:0] ST_ACC  = 3'd4;
  localparam logic [2:0] ST_UPD  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  // Product selects
  localparam logic [2:0] OP_I1A1  = 3'd0;
  localparam logic [2:0] OP_V3A2  = 3'd1;
  localparam logic [2:0] OP_I1A2  = 3'd2;
  localparam logic [2:0] OP_V3A3  = 3'd3;
  localparam logic [2:0] OP_V1K   = 3'd4;
  localparam logic [2:0] OP_BLEND = 3'd5;

  // Configuration registers
  svf_dj_pkg::cut_t  cut_r;
  svf_dj_pkg::coef_t coef_a1_r, coef_a2_r, coef_a3_r;
  svf_dj_pkg::damp_t damping_k_r;

  // Control state
  logic [2:0]       state_r, state_nxt;
  logic [2:0]       op_r, op_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic signed [S-1:0] integ_one_r, integ_one_nxt;
  logic signed [S-1:0] integ_two_r, integ_two_nxt;

  // Datapath registers
  logic signed [W-1:0]     v0_r, v0_nxt;
  logic signed [ACC_W-1:0] v3_r, v3_nxt;
  logic signed [ACC_W-1:0] v1_r, v1_nxt;
  logic signed [ACC_W-1:0] v2_r, v2_nxt;
  logic signed [ACC_W-1:0] wd_r, wd_nxt;
  logic [ACC_W-1:0]        p_r, p_nxt;
  logic signed [W-1:0]     res_r, res_nxt;
  logic signed [W-1:0]     out_sample_r, out_sample_nxt;
  logic [MAG_PAD-1:0]      mag_r, mag_nxt;
  logic [CW-1:0]           coef_r, coef_nxt;
  logic [PW-1:0]           acc_r, acc_nxt;
  logic                    neg_r, neg_nxt;
  logic                    hp_r, hp_nxt;
  logic [15:0]             blend_r, blend_nxt;

  // Combinational helpers
  logic                    in_acc_w, out_take_w, out_free_w;
  logic [16:0]             cut_neg_w;
  logic [15:0]             blend_w;
  logic                    bypass_w;
  logic signed [ACC_W-1:0] op_x_w;
  logic [CW-1:0]           op_c_w;
  logic                    op_flip_w;
  logic [ACC_W-1:0]        op_mag_w;
  logic [DW+CW-1:0]        pp_w;
  logic [PW-1:0]           rnd_sum_w, rnd_w;
  logic signed [ACC_W-1:0] base_w, term_w, sum_w, res_sat_w;
  logic signed [ACC_W-1:0] upd1_w, upd2_w, upd1_sat_w, upd2_sat_w;

  // Hold configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cut_r       <= '0;
      coef_a1_r   <= svf_dj_pkg::COEF_A1_RST;
      coef_a2_r   <= '0;
      coef_a3_r   <= '0;
      damping_k_r <= svf_dj_pkg::DAMPING_K_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        svf_dj_pkg::CFG_CUT:       cut_r       <= cfg_wdata[svf_dj_pkg::CUT_W-1:0];
        svf_dj_pkg::CFG_COEF_A1:   coef_a1_r   <= cfg_wdata[svf_dj_pkg::COEF_W-1:0];
        svf_dj_pkg::CFG_COEF_A2:   coef_a2_r   <= cfg_wdata[svf_dj_pkg::COEF_W-1:0];
        svf_dj_pkg::CFG_COEF_A3:   coef_a3_r   <= cfg_wdata[svf_dj_pkg::COEF_W-1:0];
        svf_dj_pkg::CFG_DAMPING_K: damping_k_r <= cfg_wdata[svf_dj_pkg::DAMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshakes
  assign in_stall       = (state_r != ST_IDLE);
  assign in_acc_w       = in_valid && !in_stall;
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_take_w     = out_valid_r && !out_stall;
  assign out_free_w     = !out_valid_r || !out_stall;

  // Blend magnitude and bypass decision
  assign cut_neg_w = -{cut_r[svf_dj_pkg::CUT_W-1], cut_r};
  assign blend_w   = cut_r[svf_dj_pkg::CUT_W-1] ? cut_neg_w[15:0] : cut_r;
  assign bypass_w  = (blend_w < 16'(svf_dj_pkg::BYPASS_LIMIT));

  // Select multiplier operands for the current product
  always_comb begin
    op_x_w    = '0;
    op_c_w    = '0;
    op_flip_w = 1'b0;
    case (op_r)
      OP_I1A1: begin
        op_x_w = ACC_W'(integ_one_r);
        op_c_w = CW'(coef_a1_r);
      end
      OP_V3A2: begin
        op_x_w = v3_r;
        op_c_w = CW'(coef_a2_r);
      end
      OP_I1A2: begin
        op_x_w = ACC_W'(integ_one_r);
        op_c_w = CW'(coef_a2_r);
      end
      OP_V3A3: begin
        op_x_w = v3_r;
        op_c_w = CW'(coef_a3_r);
      end
      OP_V1K: begin
        op_x_w = v1_r;
        op_c_w = CW'(damping_k_r);
      end
      OP_BLEND: begin
        // highpass keeps the negated difference, so flip its sign here
        op_x_w    = wd_r;
        op_c_w    = CW'(blend_r);
        op_flip_w = hp_r;
      end
      default: ;
    endcase
  end

  assign op_mag_w = op_x_w[ACC_W-1] ? ACC_W'(-op_x_w) : ACC_W'(op_x_w);

  // Shared multiplier: one digit of the magnitude per cycle, top digit first
  assign pp_w = (DW+CW)'(mag_r[MAG_PAD-1 -: DW]) * (DW+CW)'(coef_r);

  // Round to nearest, halves away from zero, on the magnitude
  assign rnd_sum_w = acc_r + ((op_r == OP_BLEND) ? HALF_B : HALF_C);
  assign rnd_w     = (op_r == OP_BLEND) ? (rnd_sum_w >> svf_dj_pkg::BLEND_SH)
                                        : (rnd_sum_w >> svf_dj_pkg::COEF_SH);

  // Accumulate the signed product into its destination
  always_comb begin
    base_w = '0;
    case (op_r)
      OP_I1A1:  base_w = '0;
      OP_V3A2:  base_w = v1_r;
      OP_I1A2:  base_w = ACC_W'(integ_two_r);
      OP_V3A3:  base_w = v2_r;
      OP_V1K:   base_w = v2_r;
      OP_BLEND: base_w = ACC_W'(v0_r);
      default:  base_w = '0;
    endcase
  end

  assign term_w    = signed'(p_r);
  assign sum_w     = neg_r ? (base_w - term_w) : (base_w + term_w);
  assign res_sat_w = (sum_w > SMP_MAX) ? SMP_MAX : ((sum_w < SMP_MIN) ? SMP_MIN : sum_w);

  // Integrator updates with saturation
  assign upd1_w     = (v1_r <<< 1) - ACC_W'(integ_one_r);
  assign upd2_w     = (v2_r <<< 1) - ACC_W'(integ_two_r);
  assign upd1_sat_w = (upd1_w > ST_MAX) ? ST_MAX : ((upd1_w < ST_MIN) ? ST_MIN : upd1_w);
  assign upd2_sat_w = (upd2_w > ST_MAX) ? ST_MAX : ((upd2_w < ST_MIN) ? ST_MIN : upd2_w);

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_take_w ? 1'b0 : out_valid_r;
    integ_one_nxt  = integ_one_r;
    integ_two_nxt  = integ_two_r;
    v0_nxt         = v0_r;
    v3_nxt         = v3_r;
    v1_nxt         = v1_r;
    v2_nxt         = v2_r;
    wd_nxt         = wd_r;
    p_nxt          = p_r;
    res_nxt        = res_r;
    out_sample_nxt = out_sample_r;
    mag_nxt        = mag_r;
    coef_nxt       = coef_r;
    acc_nxt        = acc_r;
    neg_nxt        = neg_r;
    hp_nxt         = hp_r;
    blend_nxt      = blend_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc_w) begin
          v0_nxt    = in_sample_in;
          blend_nxt = blend_w;
          hp_nxt    = !cut_r[svf_dj_pkg::CUT_W-1];
          if (bypass_w) begin
            // pass the sample straight through, states frozen
            res_nxt   = in_sample_in;
            state_nxt = ST_OUT;
          end else begin
            v3_nxt    = ACC_W'(in_sample_in) - ACC_W'(integ_two_r);
            op_nxt    = OP_I1A1;
            state_nxt = ST_LOAD;
          end
        end
      end

      ST_LOAD: begin
        mag_nxt   = MAG_PAD'(op_mag_w);
        neg_nxt   = op_x_w[ACC_W-1] ^ op_flip_w;
        coef_nxt  = op_c_w;
        acc_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_MUL;
      end

      ST_MUL: begin
        acc_nxt = (acc_r << DW) + PW'(pp_w);
        mag_nxt = mag_r << DW;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIGITS - 1)) begin
          state_nxt = ST_RND;
        end
      end

      ST_RND: begin
        p_nxt     = rnd_w[ACC_W-1:0];
        state_nxt = ST_ACC;
      end

      ST_ACC: begin
        state_nxt = ST_LOAD;
        case (op_r)
          OP_I1A1: begin
            v1_nxt = sum_w;
            op_nxt = OP_V3A2;
          end
          OP_V3A2: begin
            v1_nxt = sum_w;
            op_nxt = OP_I1A2;
          end
          OP_I1A2: begin
            v2_nxt = sum_w;
            op_nxt = OP_V3A3;
          end
          OP_V3A3: begin
            v2_nxt    = sum_w;
            state_nxt = ST_UPD;
          end
          OP_V1K: begin
            // v2 + k*v1, the negated wet minus dry difference
            wd_nxt = sum_w;
            op_nxt = OP_BLEND;
          end
          OP_BLEND: begin
            res_nxt   = res_sat_w[W-1:0];
            state_nxt = ST_OUT;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end

      ST_UPD: begin
        integ_one_nxt = upd1_sat_w[S-1:0];
        integ_two_nxt = upd2_sat_w[S-1:0];
        state_nxt     = ST_LOAD;
        if (hp_r) begin
          op_nxt = OP_V1K;
        end else begin
          wd_nxt = v2_r - ACC_W'(v0_r);
          op_nxt = OP_BLEND;
        end
      end

      ST_OUT: begin
        if (out_free_w) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = res_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_I1A1;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      integ_one_r <= '0;
      integ_two_r <= '0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      integ_one_r <= integ_one_nxt;
      integ_two_r <= integ_two_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    v0_r         <= v0_nxt;
    v3_r         <= v3_nxt;
    v1_r         <= v1_nxt;
    v2_r         <= v2_nxt;
    wd_r         <= wd_nxt;
    p_r          <= p_nxt;
    res_r        <= res_nxt;
    out_sample_r <= out_sample_nxt;
    mag_r        <= mag_nxt;
    coef_r       <= coef_nxt;
    acc_r        <= acc_nxt;
    neg_r        <= neg_nxt;
    hp_r         <= hp_nxt;
    blend_r      <= blend_nxt;
  end

  // A bypassed transaction leaves both integrators untouched
  a_bypass_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && bypass_w) |=>
      ($stable(integ_one_r) && $stable(integ_two_r)))
    else $error("integrator changed on a bypassed transaction");

  // A new result only appears from the final sequencer step
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result presented outside the output step");

  // Integrators move only in the update step
  a_integ_update: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (!$stable(integ_one_r) || !$stable(integ_two_r))) |->
      $past(state_r == ST_UPD))
    else $error("integrator changed outside the update step");

  // Digit counter never runs past the last digit
  a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (cnt_r <= CNT_W'(DIGITS - 1)))
    else $error("multiplier digit counter out of range");

endmodule

`default_nettype wire

@@ bench/svf_dj_filter_checker.sv @@
// Watches the sample channels and config port, predicts each filtered sample and compares.
`timescale 1ns / 1ps

module svf_dj_filter_checker
  import svf_dj_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int STATE_WIDTH  = STATE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  cfg_idx_t                       cfg_index,
  input  cfg_data_t                      cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] out_sample_out,
  output int                             fail_count,
  output int                             pending
);

  // Shadow copy of the register file
  cut_t  cut_reg;
  coef_t a1_reg;
  coef_t a2_reg;
  coef_t a3_reg;
  damp_t k_reg;

  // Integrator states: band (first) and low (second), kept saturated to STATE_WIDTH
  longint band_state;
  longint low_state;

  // Filtered samples still owed by the block, oldest first
  logic signed [SAMPLE_WIDTH-1:0] filtered_due[$];

  // Scale x by c / 2^sh, rounding halves away from zero
  function automatic longint scale_round(input longint x, input longint unsigned c,
                                         input int sh);
    logic [127:0] mag;
    logic [127:0] prod;
    longint       r;
    mag  = 128'((x < 0) ? -x : x);
    prod = (mag * 128'(c) + (128'd1 << (sh - 1))) >> sh;
    r    = longint'(prod[63:0]);
    return (x < 0) ? -r : r;
  endfunction

  // Clamp to the signed range of a w-bit value
  function automatic longint clamp_bits(input longint v, input int w);
    longint top_v;
    longint bot_v;
    top_v = (longint'(1) << (w - 1)) - 1;
    bot_v = -top_v - 1;
    if (v > top_v) return top_v;
    if (v < bot_v) return bot_v;
    return v;
  endfunction

  // One sample through the SVF and the dry/wet blend; advances the integrators
  function automatic longint filtered_sample(input longint x);
    longint blend;
    longint v1;
    longint v2;
    longint v3;
    longint wet;
    longint y;
    blend = (cut_reg < 0) ? -longint'(cut_reg) : longint'(cut_reg);
    if (blend < BYPASS_LIMIT) begin
      // Bypass: pass the dry sample, freeze the states
      y = x;
    end else begin
      v3 = x - low_state;
      v1 = scale_round(band_state, a1_reg, COEF_SH) + scale_round(v3, a2_reg, COEF_SH);
      v2 = low_state + scale_round(band_state, a2_reg, COEF_SH)
         + scale_round(v3, a3_reg, COEF_SH);
      if (cut_reg < 0) begin
        wet = v2;
      end else begin
        wet = x - scale_round(v1, k_reg, COEF_SH) - v2;
      end
      band_state = clamp_bits(2 * v1 - band_state, STATE_WIDTH);
      low_state  = clamp_bits(2 * v2 - low_state, STATE_WIDTH);
      y = x + scale_round(wet - x, blend, BLEND_SH);
    end
    return clamp_bits(y, SAMPLE_WIDTH);
  endfunction

  function automatic void log_fault(input string msg);
    if (fail_count < 10) begin
      $display("%0t: %s", $time, msg);
    end
    fail_count++;
  endfunction

  always @(posedge clk) begin
    logic signed [SAMPLE_WIDTH-1:0] want;
    if (!rst_n) begin
      // Mirror the block's reset
      cut_reg    = '0;
      a1_reg     = COEF_A1_RST;
      a2_reg     = '0;
      a3_reg     = '0;
      k_reg      = DAMPING_K_RST;
      band_state = 0;
      low_state  = 0;
      filtered_due.delete();
    end else begin
      // Compare the outgoing transaction before queueing a new one
      if (out_valid && !out_stall) begin
        if (filtered_due.size() == 0) begin
          log_fault($sformatf("sample_out %0d with no sample pending", out_sample_out));
        end else begin
          want = filtered_due.pop_front();
          if (out_sample_out !== want) begin
            log_fault($sformatf("sample_out mismatch: expected %0d, got %0d",
                                want, out_sample_out));
          end
        end
      end
      if (in_valid && !in_stall) begin
        filtered_due.push_back(SAMPLE_WIDTH'(filtered_sample(longint'(in_sample_in))));
      end
      // Register writes; upper bits beyond each register are dropped
      if (cfg_we) begin
        case (cfg_index)
          CFG_CUT:       cut_reg = cfg_wdata[CUT_W-1:0];
          CFG_COEF_A1:   a1_reg  = cfg_wdata[COEF_W-1:0];
          CFG_COEF_A2:   a2_reg  = cfg_wdata[COEF_W-1:0];
          CFG_COEF_A3:   a3_reg  = cfg_wdata[COEF_W-1:0];
          CFG_DAMPING_K: k_reg   = cfg_wdata[DAMP_W-1:0];
          default: ;
        endcase
      end
    end
    pending = filtered_due.size();
  end

endmodule

@@ bench/tb_svf_dj_filter_top.sv @@
// Stimulus, clock, reset and verdict for the state-variable DJ filter.
`timescale 1ns / 1ps

module tb_svf_dj_filter_top;
  import svf_dj_pkg::*;

  localparam int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF;
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int RX_HOLD      = 500;
  localparam int TAIL_CYCLES  = 40;

  localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // Top of the documented ranges: 1.0 for the coefficients, 2.0 for damping
  localparam coef_t COEF_FULL = COEF_A1_RST;
  localparam damp_t DAMP_FULL = DAMPING_K_RST;
  localparam real   Q30_ONE   = COEF_FULL;

  localparam cut_t CUT_FULL_NEG = {1'b1, {(CUT_W-1){1'b0}}};
  localparam cut_t CUT_FULL_POS = {1'b0, {(CUT_W-1){1'b1}}};

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  cfg_idx_t                       cfg_index = CFG_CUT;
  cfg_data_t                      cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic signed [SAMPLE_WIDTH-1:0] in_sample_in = '0;
  logic                           out_stall = 1'b0;
  wire                            in_stall;
  wire                            out_valid;
  wire signed [SAMPLE_WIDTH-1:0]  out_sample_out;

  int fail_count;
  int pending;

  bit rx_hold_req = 1'b0;
  bit steady_feed = 1'b0;
  int burst_left = 1;
  logic signed [SAMPLE_WIDTH-1:0] prev_sample = '0;

  always #5 clk = ~clk;

  svf_dj_filter_top #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .STATE_WIDTH  (STATE_WIDTH_DEF)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out)
  );

  svf_dj_filter_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .STATE_WIDTH  (STATE_WIDTH_DEF)
  ) u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // Receiver: stall in stretches of random density; on request hold off for a long run
  initial begin
    int span;
    int pct;
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        span = RX_HOLD;
        pct  = 100;
      end else begin
        span = $urandom_range(1, 60);
        case ($urandom_range(0, 3))
          0:       pct = 0;
          1:       pct = 25;
          2:       pct = 60;
          default: pct = 90;
        endcase
      end
      repeat (span) begin
        out_stall <= ($urandom_range(0, 99) < pct);
        @(posedge clk);
      end
    end
  end

  // Give up on a hang
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_svf_dj_filter_top: FAIL");
    $finish;
  end

  // Offer one sample and hold it until the transaction completes, then maybe idle
  task automatic put_sample(input logic signed [SAMPLE_WIDTH-1:0] s);
    int gap;
    in_valid     <= 1'b1;
    in_sample_in <= s;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (steady_feed || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop offering and wait until every filtered sample has been taken
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic cfg_beat(input cfg_idx_t idx, input cfg_data_t data);
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Write all registers, with junk in any unused upper bits, plus one write off the map
  task automatic program_filter(input cut_t cut_v, input coef_t a1_v, input coef_t a2_v,
                                input coef_t a3_v, input damp_t k_v);
    cfg_we <= 1'b1;
    cfg_beat(CFG_CUT, {16'($urandom()), cut_v});
    cfg_beat(CFG_COEF_A1, {1'($urandom()), a1_v});
    cfg_beat(CFG_COEF_A2, {1'($urandom()), a2_v});
    cfg_beat(CFG_COEF_A3, {1'($urandom()), a3_v});
    cfg_beat(CFG_DAMPING_K, k_v);
    cfg_beat(cfg_idx_t'($urandom_range(int'(CFG_DAMPING_K) + 1, (1 << CFG_IDX_W) - 1)),
             $urandom());
    cfg_we <= 1'b0;
  endtask

  // Coefficients of a sensible filter from g and k given in thousandths
  task automatic tuned_coefs(input int g_milli, input int k_milli, output coef_t a1,
                             output coef_t a2, output coef_t a3, output damp_t k);
    real g;
    real r1;
    g  = g_milli / 1000.0;
    r1 = 1.0 / (1.0 + g * (g + k_milli / 1000.0));
    a1 = coef_t'($rtoi(r1 * Q30_ONE));
    a2 = coef_t'($rtoi(g * r1 * Q30_ONE));
    a3 = coef_t'($rtoi(g * g * r1 * Q30_ONE));
    k  = damp_t'((longint'(k_milli) << COEF_SH) / 1000);
  endtask

  // Random setting: mostly tuned filters, some raw and extreme coefficient sets
  task automatic pick_setting();
    cut_t  c;
    coef_t a1;
    coef_t a2;
    coef_t a3;
    damp_t k;
    int    roll;
    case ($urandom_range(0, 7))
      0:       c = CUT_FULL_NEG;
      1:       c = CUT_FULL_POS;
      2:       c = cut_t'($urandom_range(0, 2 * (BYPASS_LIMIT - 1)) - (BYPASS_LIMIT - 1));
      3:       c = $urandom_range(0, 1) ? cut_t'(BYPASS_LIMIT) : cut_t'(-BYPASS_LIMIT);
      default: c = cut_t'($urandom());
    endcase
    roll = $urandom_range(0, 9);
    if (roll < 7) begin
      tuned_coefs($urandom_range(1, 3000), $urandom_range(0, 2000), a1, a2, a3, k);
    end else if (roll == 7) begin
      a1 = coef_t'($urandom_range(0, COEF_FULL));
      a2 = coef_t'($urandom_range(0, COEF_FULL));
      a3 = coef_t'($urandom_range(0, COEF_FULL));
      k  = damp_t'($urandom_range(0, DAMP_FULL));
    end else if (roll == 8) begin
      // Beyond the documented ranges, still within the register widths
      a1 = coef_t'($urandom());
      a2 = coef_t'($urandom());
      a3 = coef_t'($urandom());
      k  = damp_t'($urandom());
    end else begin
      a1 = $urandom_range(0, 1) ? COEF_FULL : '0;
      a2 = $urandom_range(0, 1) ? COEF_FULL : '0;
      a3 = $urandom_range(0, 1) ? COEF_FULL : '0;
      k  = $urandom_range(0, 1) ? DAMP_FULL : '0;
    end
    program_filter(c, a1, a2, a3, k);
  endtask

  // Audio-ish content: full-scale noise, extremes, quiet passages and held values
  function automatic logic signed [SAMPLE_WIDTH-1:0] audio_sample();
    logic signed [SAMPLE_WIDTH-1:0] s;
    case ($urandom_range(0, 9))
      0:       s = S_MAX;
      1:       s = S_MIN;
      2, 3:    s = SAMPLE_WIDTH'(int'($urandom_range(0, 1023)) - 512);
      4, 5:    s = prev_sample;
      default: s = SAMPLE_WIDTH'($urandom());
    endcase
    prev_sample = s;
    return s;
  endfunction

  initial begin
    coef_t a1;
    coef_t a2;
    coef_t a3;
    damp_t k;
    int    n;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: cut of zero bypasses
    put_sample(S_MAX);
    put_sample(S_MIN);
    put_sample('0);
    drain();

    // Just under the bypass threshold, both signs
    tuned_coefs(500, 1000, a1, a2, a3, k);
    program_filter(cut_t'(BYPASS_LIMIT - 1), a1, a2, a3, k);
    put_sample(SAMPLE_WIDTH'(1));
    put_sample(SAMPLE_WIDTH'(-1));
    drain();
    program_filter(cut_t'(-(BYPASS_LIMIT - 1)), a1, a2, a3, k);
    put_sample(S_MAX);
    drain();

    // Smallest blend that filters, highpass then lowpass
    program_filter(cut_t'(BYPASS_LIMIT), a1, a2, a3, k);
    put_sample(S_MAX);
    put_sample(SAMPLE_WIDTH'(1234));
    drain();
    program_filter(cut_t'(-BYPASS_LIMIT), a1, a2, a3, k);
    put_sample(S_MIN);
    drain();

    // Full negative cut: pure lowpass
    tuned_coefs(200, 700, a1, a2, a3, k);
    program_filter(CUT_FULL_NEG, a1, a2, a3, k);
    put_sample(S_MAX);
    put_sample(S_MAX);
    put_sample(S_MIN);
    drain();

    // Maximal coefficients: drive the integrators and the output into saturation
    program_filter(CUT_FULL_POS, COEF_FULL, COEF_FULL, COEF_FULL, DAMP_FULL);
    put_sample(S_MAX);
    put_sample(S_MIN);
    put_sample(S_MAX);
    put_sample(S_MIN);
    drain();
    program_filter(CUT_FULL_NEG, COEF_FULL, COEF_FULL, COEF_FULL, DAMP_FULL);
    put_sample(S_MAX);
    put_sample(S_MAX);
    put_sample(S_MAX);
    drain();

    // Zero coefficients and damping, highpass
    program_filter(CUT_FULL_POS, '0, '0, '0, '0);
    put_sample(S_MIN);
    put_sample(S_MAX);

    // Random phases, each under a fresh setting; one phase fills the block against a held receiver
    for (int phase = 0; phase < 12; phase++) begin
      drain();
      pick_setting();
      if (phase == 3) begin
        rx_hold_req = 1'b1;
        steady_feed = 1'b1;
      end
      n = $urandom_range(130, 200);
      for (int i = 0; i < n; i++) begin
        if (i == 40) steady_feed = 1'b0;
        put_sample(audio_sample());
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_svf_dj_filter_top: PASS");
    end else begin
      $display("tb_svf_dj_filter_top: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/svf_dj_pkg.sv
src/svf_dj_filter_top.sv
bench/svf_dj_filter_checker.sv
bench/tb_svf_dj_filter_top.sv
